// ===== rtl/track_distance_statistics_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros shared by the statistics block.
// ----------------------------------------------------------------------------
`ifndef TRACK_DISTANCE_STATISTICS_MACROS_SVH
`define TRACK_DISTANCE_STATISTICS_MACROS_SVH

`ifndef NO_ASSERTIONS

// Implication in the same cycle, checked on the rising edge of clk.
`define TDS_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication into the following cycle.
`define TDS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define TDS_ASSERT_SAME(lbl, ante, cons, msg)
`define TDS_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== rtl/tds_pkg.sv =====
// ----------------------------------------------------------------------------
// tds_pkg
// Types and constants of the per-track distance statistics block.
// ----------------------------------------------------------------------------
package tds_pkg;

	// Configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_LANE_MARGIN = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LANE_PITCH  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DIST_STEP   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SNAP_STEP   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_RECENT  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_RATE  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MM_PER_PX   = 3'd6;

	// Ring slot pointer, wide enough for the largest ring.
	localparam int SLOT_W = 6;

	// Fixed-point widths.
	localparam int PATH_W = 40;
	localparam int POS_W  = 17;

	// One table entry per track.
	typedef struct packed {
		logic              seen;
		logic [31:0]       first_frame;
		logic [POS_W-1:0]  anchor_x;
		logic [POS_W-1:0]  anchor_y;
		logic [31:0]       anchor_frame;
		logic [PATH_W-1:0] path;
		logic [15:0]       peak;
		logic [31:0]       snap_cnt;
		logic [SLOT_W-1:0] snap_ptr;
	} trk_word_t;

	// One ring snapshot.
	typedef struct packed {
		logic [31:0]       frame;
		logic [PATH_W-1:0] path;
	} ring_word_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_CLEAR,
		S_LOAD,
		S_SUM,
		S_SQRT,
		S_PATH,
		S_WB,
		S_OLD,
		S_RCHK,
		S_M1,
		S_M2,
		S_M3,
		S_M4,
		S_D1,
		S_D2,
		S_DIVI,
		S_DIV,
		S_DONE
	} state_t;

endpackage

// ===== rtl/tds_ram.sv =====
// ----------------------------------------------------------------------------
// tds_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tds_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port with registered data.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/track_distance_statistics.sv =====
// ----------------------------------------------------------------------------
// track_distance_statistics
// Per-track statistics table: path length, peak and recent speed, lane.
// ----------------------------------------------------------------------------
// Usage: a detection is a transaction accepted when start is high and busy is
// low. Each accepted detection gives exactly one result, shown for one cycle
// with done high; the receiver has no way to stall it.
// A ghost detection (lost high) gives its result in the next cycle and the
// block is free again at once, so ghosts can follow one per cycle. A real
// detection is worked through by a sequencer before done rises: the per-track
// entry is read, modified and written back in a track memory, the ring of
// snapshots lives in a second memory, and the time is set by the 18-step
// square root and the 16-step divider for the recent speed. busy stays high
// until done rises, so a new real detection is taken only after the last one
// is through. After reset the block sweeps the track memory, one entry a
// cycle, with busy high; configuration writes are taken at any time.
// Registers are written through cfg_we, cfg_index and cfg_data, and should be
// changed only while the block is idle.
// ----------------------------------------------------------------------------
`include "track_distance_statistics_macros.svh"

module track_distance_statistics import tds_pkg::*; #(
	parameter int TRACKS     = 256,
	parameter int RING_SLOTS = 16,
	parameter int NUM_LANES  = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Configuration port.
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// Detection input.
	input  logic                  start,
	output logic                  busy,
	input  logic [31:0]           frame_index,
	input  logic [7:0]            person_id,
	input  logic [16:0]           center_x,
	input  logic [16:0]           center_y,
	input  logic [15:0]           speed_mmps,
	input  logic                  speed_valid,
	input  logic                  lost,
	// Result output.
	output logic                  done,
	output logic [7:0]            out_track_id,
	output logic                  counted,
	output logic [3:0]            lane,
	output logic [31:0]           distance_mm,
	output logic [15:0]           peak_speed_mmps,
	output logic [15:0]           recent_speed_mmps,
	output logic                  recent_valid,
	output logic [31:0]           observed_frames,
	output logic [31:0]           person_total,
	output logic [31:0]           ghost_total
);

	localparam int TW   = $clog2(TRACKS);
	localparam int RD   = TRACKS * RING_SLOTS;
	localparam int RAW  = $clog2(RD);
	localparam int TRKW = $bits(trk_word_t);
	localparam int RNGW = $bits(ring_word_t);

	// ------------------------------------------------------------------
	// Configuration registers.
	// ------------------------------------------------------------------
	logic [15:0] margin_q, pitch_q;
	logic [7:0]  dstep_q, sstep_q, frate_q;
	logic [11:0] minr_q;
	logic [23:0] mm_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_q <= 16'd0;
			pitch_q  <= 16'd250;
			dstep_q  <= 8'd5;
			sstep_q  <= 8'd25;
			minr_q   <= 12'd75;
			frate_q  <= 8'd25;
			mm_q     <= 24'd65536;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LANE_MARGIN: margin_q <= cfg_data[15:0];
				REG_LANE_PITCH:  pitch_q  <= cfg_data[15:0];
				REG_DIST_STEP:   dstep_q  <= cfg_data[7:0];
				REG_SNAP_STEP:   sstep_q  <= cfg_data[7:0];
				REG_MIN_RECENT:  minr_q   <= cfg_data[11:0];
				REG_FRAME_RATE:  frate_q  <= cfg_data[7:0];
				REG_MM_PER_PX:   mm_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Control state.
	// ------------------------------------------------------------------
	state_t        state_q, state_d;
	logic [TW-1:0] clr_q;
	logic [4:0]    iter_q;
	logic          accept;

	assign accept = start && !busy;

	// Entry index: track id modulo TRACKS by shifted compare and subtract.
	logic [20:0]   trem;
	logic [TW-1:0] entry_in;

	always_comb begin
		trem = 21'(person_id);
		for (int j = 7; j >= 0; j--) begin
			if (trem >= (21'(TRACKS) << j)) begin
				trem = trem - (21'(TRACKS) << j);
			end
		end
		entry_in = trem[TW-1:0];
	end

	// ------------------------------------------------------------------
	// Memories.
	// ------------------------------------------------------------------
	logic             trk_we, trk_re, ring_we, ring_re;
	logic [TW-1:0]    trk_waddr, trk_raddr;
	trk_word_t        trk_wdata, trk_rdata;
	logic [RAW-1:0]   ring_waddr, ring_raddr;
	ring_word_t       ring_wdata, ring_rdata;

	tds_ram #(.WIDTH(TRKW), .DEPTH(TRACKS)) u_trk_ram (
		.clk   (clk),
		.we    (trk_we),
		.waddr (trk_waddr),
		.wdata (trk_wdata),
		.re    (trk_re),
		.raddr (trk_raddr),
		.rdata (trk_rdata)
	);

	tds_ram #(.WIDTH(RNGW), .DEPTH(RD)) u_ring_ram (
		.clk   (clk),
		.we    (ring_we),
		.waddr (ring_waddr),
		.wdata (ring_wdata),
		.re    (ring_re),
		.raddr (ring_raddr),
		.rdata (ring_rdata)
	);

	// ------------------------------------------------------------------
	// Working registers of the current detection.
	// ------------------------------------------------------------------
	logic [31:0]       fr_q;
	logic [7:0]        id_q;
	logic [POS_W-1:0]  cx_q, cy_q;
	logic [15:0]       spd_q;
	logic              spd_ok_q;
	logic [TW-1:0]     e_q;
	logic [31:0]       first_q, af_q, cnt_q, dt_q;
	logic [POS_W-1:0]  ax_q, ay_q;
	logic [PATH_W-1:0] path_q, diff_q;
	logic [15:0]       peak_q;
	logic [SLOT_W-1:0] ptr_q, wslot_q, oslot_q;
	logic              upd_q, snap_q, rvalid_q, sat_q;
	logic [33:0]       sqx_q, sqy_q;
	logic [35:0]       v_q, res_q, bit_q;
	logic [43:0]       mul_q, mlo_q;
	logic [51:0]       x_q;
	logic [59:0]       num_q, rem_q;
	logic [55:0]       dsh_q;
	logic [15:0]       quo_q;
	logic [31:0]       dist_q;
	logic [31:0]       real_q, ghost_q;

	// Ring addresses of this entry.
	logic [RAW-1:0] ring_base;
	assign ring_base = RAW'(RAW'(e_q) * RAW'(RING_SLOTS));

	// Entry as loaded, with a fresh track initialized.
	logic [31:0]       ld_first, ld_af;
	logic [POS_W-1:0]  ld_ax, ld_ay, dx, dy;
	logic [PATH_W-1:0] ld_path;
	logic [7:0]        dstep_eff, sstep_eff;
	logic [SLOT_W-1:0] last_slot;

	always_comb begin
		if (trk_rdata.seen) begin
			ld_first = trk_rdata.first_frame;
			ld_ax    = trk_rdata.anchor_x;
			ld_ay    = trk_rdata.anchor_y;
			ld_af    = trk_rdata.anchor_frame;
			ld_path  = trk_rdata.path;
		end else begin
			ld_first = fr_q;
			ld_ax    = cx_q;
			ld_ay    = cy_q;
			ld_af    = fr_q;
			ld_path  = '0;
		end
		dx = (cx_q >= ld_ax) ? cx_q - ld_ax : ld_ax - cx_q;
		dy = (cy_q >= ld_ay) ? cy_q - ld_ay : ld_ay - cy_q;
		dstep_eff = (dstep_q == 8'd0) ? 8'd1 : dstep_q;
		sstep_eff = (sstep_q == 8'd0) ? 8'd1 : sstep_q;
		last_slot = (trk_rdata.snap_ptr == '0) ? SLOT_W'(RING_SLOTS - 1)
			: trk_rdata.snap_ptr - 1'b1;
	end

	// Path update and snapshot decision.
	logic [PATH_W:0]   path_sum;
	logic [PATH_W-1:0] path_new;
	logic              snap_c;
	logic [31:0]       cnt_new;
	logic [SLOT_W-1:0] ptr_new;

	always_comb begin
		path_sum = {1'b0, path_q} + (PATH_W + 1)'(res_q[17:0]);
		if (!upd_q) begin
			path_new = path_q;
		end else if (path_sum[PATH_W]) begin
			path_new = '1;
		end else begin
			path_new = path_sum[PATH_W-1:0];
		end
		snap_c = (cnt_q == 32'd0) || ((fr_q >= ring_rdata.frame)
			&& ((fr_q - ring_rdata.frame) >= 32'(sstep_eff)));
		cnt_new = snap_c ? cnt_q + 32'd1 : cnt_q;
		if (!snap_c) begin
			ptr_new = ptr_q;
		end else if (cnt_new == 32'd0) begin
			ptr_new = '0;
		end else if (ptr_q == SLOT_W'(RING_SLOTS - 1)) begin
			ptr_new = '0;
		end else begin
			ptr_new = ptr_q + 1'b1;
		end
	end

	// Shared 20 x 24 multiplier operand.
	logic [19:0] mul_a;
	always_comb begin
		unique case (state_q)
			S_M1:    mul_a = diff_q[19:0];
			S_M2:    mul_a = diff_q[39:20];
			S_M4:    mul_a = path_q[19:0];
			default: mul_a = path_q[39:20];
		endcase
	end

	// Distance in millimeters, saturated.
	logic [44:0] dist_sum;
	assign dist_sum = {1'b0, mul_q} + 45'(mlo_q[43:20]);

	// ------------------------------------------------------------------
	// Next-state logic.
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:  if (accept && !lost) state_d = S_LOAD;
			S_CLEAR: if (clr_q == TW'(TRACKS - 1)) state_d = S_IDLE;
			S_LOAD:  state_d = S_SUM;
			S_SUM:   state_d = S_SQRT;
			S_SQRT:  if (iter_q == 5'd0) state_d = S_PATH;
			S_PATH:  state_d = S_WB;
			S_WB:    state_d = S_OLD;
			S_OLD:   state_d = S_RCHK;
			S_RCHK:  state_d = S_M1;
			S_M1:    state_d = S_M2;
			S_M2:    state_d = S_M3;
			S_M3:    state_d = S_M4;
			S_M4:    state_d = S_D1;
			S_D1:    state_d = S_D2;
			S_D2:    state_d = S_DIVI;
			S_DIVI:  state_d = S_DIV;
			S_DIV:   if (iter_q == 5'd0) state_d = S_DONE;
			S_DONE:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// ------------------------------------------------------------------
	// Output logic of the sequencer: memory controls.
	// ------------------------------------------------------------------
	always_comb begin
		busy       = (state_q != S_IDLE);
		trk_re     = 1'b0;
		trk_raddr  = entry_in;
		trk_we     = 1'b0;
		trk_waddr  = e_q;
		trk_wdata  = '0;
		ring_re    = 1'b0;
		ring_raddr = ring_base + RAW'(last_slot);
		ring_we    = 1'b0;
		ring_waddr = ring_base + RAW'(wslot_q);
		ring_wdata = '{frame: fr_q, path: path_q};
		unique case (state_q)
			S_IDLE:  trk_re = accept && !lost;
			S_CLEAR: begin
				trk_we    = 1'b1;
				trk_waddr = clr_q;
			end
			S_LOAD:  ring_re = 1'b1;
			S_WB: begin
				trk_we    = 1'b1;
				trk_wdata = '{seen: 1'b1, first_frame: first_q, anchor_x: ax_q,
					anchor_y: ay_q, anchor_frame: af_q, path: path_q, peak: peak_q,
					snap_cnt: cnt_q, snap_ptr: ptr_q};
				ring_we   = snap_q;
			end
			S_OLD: begin
				ring_re    = 1'b1;
				ring_raddr = ring_base + RAW'(oslot_q);
			end
			default: ;
		endcase
	end

	// ------------------------------------------------------------------
	// Control registers.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			iter_q  <= '0;
			real_q  <= '0;
			ghost_q <= '0;
			done    <= 1'b0;
		end else begin
			state_q <= state_d;
			done    <= (accept && lost) || (state_q == S_DONE);
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (accept) begin
				if (lost) begin
					ghost_q <= ghost_q + 32'd1;
				end else begin
					real_q <= real_q + 32'd1;
				end
			end
			// Iteration counter for the square root and the divider.
			priority if (state_q == S_SUM) begin
				iter_q <= 5'd17;
			end else if (state_q == S_DIVI) begin
				iter_q <= 5'd15;
			end else if (iter_q != 5'd0) begin
				iter_q <= iter_q - 5'd1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Lane unit: one compare and subtract of the lane pitch per cycle.
	// ------------------------------------------------------------------
	logic [19:0] m16, p16;
	logic [16:0] lrem_q;
	logic [4:0]  lk_q;
	logic        lrun_q;

	assign m16 = {margin_q, 4'd0};
	assign p16 = {pitch_q, 4'd0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lrun_q <= 1'b0;
			lk_q   <= '0;
			lrem_q <= '0;
		end else if (accept) begin
			lrun_q <= (20'(center_y) >= m16) && (pitch_q != 16'd0);
			lk_q   <= ((20'(center_y) >= m16) && (pitch_q != 16'd0)) ? 5'd1 : 5'd0;
			lrem_q <= 17'(20'(center_y) - m16);
		end else if (lrun_q) begin
			if (20'(lrem_q) >= p16) begin
				lrem_q <= lrem_q - p16[16:0];
				lk_q   <= lk_q + 5'd1;
				if (lk_q >= 5'(NUM_LANES)) begin
					lrun_q <= 1'b0;
				end
			end else begin
				lrun_q <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Datapath registers.
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				fr_q     <= frame_index;
				id_q     <= person_id;
				cx_q     <= center_x;
				cy_q     <= center_y;
				spd_q    <= speed_mmps;
				spd_ok_q <= speed_valid;
				e_q      <= entry_in;
			end
			// Entry arrives: first-seen setup, peak, anchor test, squares.
			S_LOAD: begin
				first_q <= ld_first;
				ax_q    <= ld_ax;
				ay_q    <= ld_ay;
				af_q    <= ld_af;
				path_q  <= ld_path;
				peak_q  <= (spd_ok_q && spd_q > trk_rdata.peak) ? spd_q : trk_rdata.peak;
				cnt_q   <= trk_rdata.snap_cnt;
				ptr_q   <= trk_rdata.snap_ptr;
				upd_q   <= (fr_q >= ld_af) && ((fr_q - ld_af) >= 32'(dstep_eff));
				sqx_q   <= dx * dx;
				sqy_q   <= dy * dy;
			end
			S_SUM: begin
				v_q   <= 36'(sqx_q) + 36'(sqy_q);
				res_q <= '0;
				bit_q <= 36'h4_0000_0000;
			end
			// One result bit of the integer square root per cycle.
			S_SQRT: begin
				if (v_q >= res_q + bit_q) begin
					v_q   <= v_q - (res_q + bit_q);
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			S_PATH: begin
				path_q  <= path_new;
				if (upd_q) begin
					ax_q <= cx_q;
					ay_q <= cy_q;
					af_q <= fr_q;
				end
				snap_q  <= snap_c;
				wslot_q <= ptr_q;
				cnt_q   <= cnt_new;
				ptr_q   <= ptr_new;
				oslot_q <= (cnt_new >= 32'(RING_SLOTS)) ? ptr_new : '0;
			end
			// Oldest slot arrives: window check and path gained.
			S_RCHK: begin
				rvalid_q <= (cnt_q != 32'd0) && (fr_q > ring_rdata.frame)
					&& ((fr_q - ring_rdata.frame) >= 32'(minr_q));
				dt_q     <= fr_q - ring_rdata.frame;
				diff_q   <= (path_q >= ring_rdata.path) ? path_q - ring_rdata.path : '0;
			end
			S_M1: mul_q <= mul_a * mm_q;
			S_M2: begin
				mlo_q <= mul_q;
				mul_q <= mul_a * mm_q;
			end
			S_M3: x_q <= 52'({mul_q, 8'd0}) + 52'(mlo_q[43:12]);
			S_M4: begin
				num_q <= x_q * frate_q;
				mul_q <= mul_a * mm_q;
			end
			S_D1: begin
				mlo_q <= mul_q;
				mul_q <= mul_a * mm_q;
			end
			S_D2: dist_q <= (dist_sum[44:32] != '0) ? '1 : dist_sum[31:0];
			// Divider setup with early saturation.
			S_DIVI: begin
				sat_q <= num_q >= 60'({dt_q, 24'd0});
				rem_q <= num_q;
				dsh_q <= {1'b0, dt_q, 23'd0};
				quo_q <= '0;
			end
			S_DIV: begin
				if (rem_q >= 60'(dsh_q)) begin
					rem_q <= rem_q - 60'(dsh_q);
					quo_q <= {quo_q[14:0], 1'b1};
				end else begin
					quo_q <= {quo_q[14:0], 1'b0};
				end
				dsh_q <= dsh_q >> 1;
			end
			default: ;
		endcase
	end

	// ------------------------------------------------------------------
	// Result registers.
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (accept && lost) begin
			out_track_id      <= person_id;
			counted           <= 1'b0;
			lane              <= '0;
			distance_mm       <= '0;
			peak_speed_mmps   <= '0;
			recent_speed_mmps <= '0;
			recent_valid      <= 1'b0;
			observed_frames   <= '0;
			person_total      <= real_q;
			ghost_total       <= ghost_q + 32'd1;
		end else if (state_q == S_DONE) begin
			out_track_id      <= id_q;
			counted           <= 1'b1;
			lane              <= (lk_q > 5'(NUM_LANES)) ? 4'd0 : lk_q[3:0];
			distance_mm       <= dist_q;
			peak_speed_mmps   <= peak_q;
			recent_speed_mmps <= !rvalid_q ? 16'd0 : (sat_q ? 16'hFFFF : quo_q);
			recent_valid      <= rvalid_q;
			observed_frames   <= (fr_q > first_q) ? fr_q - first_q : 32'd0;
			person_total      <= real_q;
			ghost_total       <= ghost_q;
		end
	end

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------
	`TDS_ASSERT_NEXT(a_accept_answered, start && !busy, done || busy,
		"accepted transaction neither answered nor in progress")
	`TDS_ASSERT_SAME(a_lane_range, done && counted, lane <= 4'(NUM_LANES),
		"lane number above the lane count")
	`TDS_ASSERT_SAME(a_ghost_empty, done && !counted,
		distance_mm == 32'd0 && observed_frames == 32'd0 && !recent_valid,
		"ghost result carries statistics")

endmodule
